@@ rtl/se2_exponential_map_macros.svh @@
// Assertion macros shared by the SE(2) exponential map RTL.
`ifndef SE2_EXPONENTIAL_MAP_MACROS_SVH
`define SE2_EXPONENTIAL_MAP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define SE2EM_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define SE2EM_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SE2EM_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons, msg)
`define SE2EM_ASSERT_NXT(lbl, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

@@ rtl/se2em_pkg.sv @@
// Constants and helpers for the SE(2) exponential map pipeline.
`default_nettype none

package se2em_pkg;

    localparam int ZW = 36;
    localparam int XW = 34;
    localparam int CORDIC_MAX = 32;

    localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XW-1:0] Q30_ONE_X   = 34'sd1073741824;
    localparam logic signed [31:0]   Q30_ONE     = 32'sd1073741824;
    localparam logic signed [32:0]   Q30_ONE_33  = 33'sd1073741824;

    localparam logic [30:0] TOL_RESET = 31'd268;

    // Divider: numerator, divisor, quotient and compare widths.
    localparam int DIV_NW = 65;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 34;
    localparam int DIV_CW = 70;

    localparam logic [DIV_QW-1:0] Q_POS_MAX = 34'h0_7FFF_FFFF;
    localparam logic [DIV_QW-1:0] Q_NEG_MAX = 34'h0_8000_0000;

    // Rounded atan(2^-i) in Q.30 radians.
    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd11: r = 36'sd524288;
            5'd12: r = 36'sd262144;
            5'd13: r = 36'sd131072;
            5'd14: r = 36'sd65536;
            5'd15: r = 36'sd32768;
            5'd16: r = 36'sd16384;
            5'd17: r = 36'sd8192;
            5'd18: r = 36'sd4096;
            5'd19: r = 36'sd2048;
            5'd20: r = 36'sd1024;
            5'd21: r = 36'sd512;
            5'd22: r = 36'sd256;
            5'd23: r = 36'sd128;
            5'd24: r = 36'sd64;
            5'd25: r = 36'sd32;
            5'd26: r = 36'sd16;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            5'd30: r = 36'sd1;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/se2em_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module se2em_div
    import se2em_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_QW-1:0] quo,
    output logic              big
);

    logic [DIV_NW-1:0] rem_reg [DIV_QW-1];
    logic [DIV_DW-1:0] den_reg [DIV_QW-1];
    logic [DIV_QW-1:0] quo_reg [DIV_QW];
    logic              big_reg [DIV_QW];

    for (genvar j = 0; j < DIV_QW; j++) begin : g_step
        localparam int K = DIV_QW - 1 - j;
        logic [DIV_NW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QW-1:0] quo_in;
        logic              big_in;
        logic [DIV_CW-1:0] sub;
        logic              ge;
        logic [DIV_NW-1:0] rem_next;
        logic [DIV_QW-1:0] quo_next;

        if (j == 0) begin : g_first
            // Quotient too wide for the pipeline: flag it for saturation.
            assign big_in = ({{(DIV_CW-DIV_NW){1'b0}}, num}
                             >= ({{(DIV_CW-DIV_DW){1'b0}}, den} << DIV_QW));
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else begin : g_next
            assign big_in = big_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign sub      = {{(DIV_CW-DIV_DW){1'b0}}, den_in} << K;
        assign ge       = {{(DIV_CW-DIV_NW){1'b0}}, rem_in} >= sub;
        assign rem_next = ge ? (rem_in - sub[DIV_NW-1:0]) : rem_in;
        assign quo_next = ge ? (quo_in | (DIV_QW'(1) << K)) : quo_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j] <= quo_next;
                big_reg[j] <= big_in;
            end
        end

        if (j < DIV_QW - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[DIV_QW-1];
    assign big = big_reg[DIV_QW-1];

endmodule

`default_nettype wire

@@ rtl/se2_exponential_map.sv @@
// Top level of the SE(2) exponential map: twist in, rotation and translation out.
// Throughput: one request per cycle while the output is not stalled; the whole pipeline advances on one enable.
// Most of the pipeline depth comes from the CORDIC stages and the 34 bit-per-stage divider steps.
// Reset clears all stage valid bits and loads the tolerance register with 268.
`default_nettype none
`include "se2_exponential_map_macros.svh"

module se2_exponential_map
    import se2em_pkg::*;
#(
    parameter int ROTATION_STAGES = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] rotation_rate,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cos_theta,
    output logic signed [31:0] sin_theta,
    output logic signed [31:0] trans_x,
    output logic signed [31:0] trans_y,
    output logic               linear_path,
    output logic               overflow,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data
);

    // Stages beyond 32 would rotate by zero; cap them.
    localparam int NS  = (ROTATION_STAGES > CORDIC_MAX) ? CORDIC_MAX : ROTATION_STAGES;
    // Range reduction (2), CORDIC (NS), flip/clamp, multiply, sum, abs,
    // numerator add (5), divider (DIV_QW), output (1).
    localparam int LAT = NS + 8 + DIV_QW;

    typedef struct packed {
        logic               lin;
        logic               w_neg;
        logic [31:0]        absw;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } pre_t;

    typedef struct packed {
        logic               lin;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic               negx;
        logic               negy;
    } post_t;

    // ------------------------------------------------------------------
    // Flow control: one enable moves every stage; a stalled output
    // register holds the whole pipe so nothing is lost or repeated.
    // ------------------------------------------------------------------
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic [30:0]    tol_reg;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];
    assign cfg_ready = 1'b1;
    assign vld_next  = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            tol_reg <= TOL_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: take the angle to Q.30, wrap once by 2*pi, decide path.
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] z_in;
    logic [31:0]          mag_in;
    logic signed [ZW-1:0] z1_next;
    pre_t                 pre1_next;
    logic signed [ZW-1:0] z1_reg;
    pre_t                 pre1_reg;

    assign z_in   = {{(ZW-34){rotation_rate[31]}}, rotation_rate, 2'b00};
    assign mag_in = rotation_rate[31] ? (~rotation_rate + 32'd1) : rotation_rate;

    always_comb
    begin
        if (z_in > Q30_PI)
        begin
            z1_next = z_in - Q30_TWO_PI;
        end
        else if (z_in < -Q30_PI)
        begin
            z1_next = z_in + Q30_TWO_PI;
        end
        else
        begin
            z1_next = z_in;
        end
        // Zero angle always takes the linear path, even with zero tolerance.
        pre1_next.lin   = (rotation_rate == 32'sd0) || (mag_in < {1'b0, tol_reg});
        pre1_next.w_neg = rotation_rate[31];
        pre1_next.absw  = mag_in;
        pre1_next.vx    = rate_x;
        pre1_next.vy    = rate_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z1_reg   <= z1_next;
            pre1_reg <= pre1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: fold into [-pi/2, pi/2]; remember to negate cos and sin.
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] z2_next;
    logic                 flip2_next;
    logic signed [ZW-1:0] z2_reg;
    logic                 flip2_reg;
    pre_t                 pre2_reg;

    always_comb
    begin
        if (z1_reg > Q30_HALF_PI)
        begin
            z2_next    = z1_reg - Q30_PI;
            flip2_next = 1'b1;
        end
        else if (z1_reg < -Q30_HALF_PI)
        begin
            z2_next    = z1_reg + Q30_PI;
            flip2_next = 1'b1;
        end
        else
        begin
            z2_next    = z1_reg;
            flip2_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z2_reg    <= z2_next;
            flip2_reg <= flip2_next;
            pre2_reg  <= pre1_reg;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC rotation, one micro-rotation per register stage.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx_reg   [NS];
    logic signed [XW-1:0] cy_reg   [NS];
    logic signed [ZW-1:0] cz_reg   [NS-1];
    logic                 cflip_reg[NS];
    pre_t                 cpre_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] zc_in;
        logic                 flip_in;
        pre_t                 pre_in;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] ang;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0) begin : g_head
            assign x_in    = CORDIC_GAIN;
            assign y_in    = '0;
            assign zc_in   = z2_reg;
            assign flip_in = flip2_reg;
            assign pre_in  = pre2_reg;
        end
        else begin : g_body
            assign x_in    = cx_reg[i-1];
            assign y_in    = cy_reg[i-1];
            assign zc_in   = cz_reg[i-1];
            assign flip_in = cflip_reg[i-1];
            assign pre_in  = cpre_reg[i-1];
        end

        assign dx  = y_in >>> i;
        assign dy  = x_in >>> i;
        assign ang = atan_q30(5'(i));

        always_comb
        begin
            if (!zc_in[ZW-1])
            begin
                x_next = x_in - dx;
                y_next = y_in + dy;
                z_next = zc_in - ang;
            end
            else
            begin
                x_next = x_in + dx;
                y_next = y_in - dy;
                z_next = zc_in + ang;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[i]    <= x_next;
                cy_reg[i]    <= y_next;
                cflip_reg[i] <= flip_in;
                cpre_reg[i]  <= pre_in;
            end
        end

        // The last stage has no use for the residual angle.
        if (i < NS - 1) begin : g_zkeep
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cz_reg[i] <= z_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Flip and clamp to [-1, 1] in Q1.30.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] xf;
    logic signed [XW-1:0] yf;
    logic signed [31:0]   c_f_next;
    logic signed [31:0]   s_f_next;
    logic signed [31:0]   c_f_reg;
    logic signed [31:0]   s_f_reg;
    pre_t                 pre_f_reg;

    assign xf = cflip_reg[NS-1] ? -cx_reg[NS-1] : cx_reg[NS-1];
    assign yf = cflip_reg[NS-1] ? -cy_reg[NS-1] : cy_reg[NS-1];

    always_comb
    begin
        if (xf > Q30_ONE_X)
        begin
            c_f_next = Q30_ONE;
        end
        else if (xf < -Q30_ONE_X)
        begin
            c_f_next = -Q30_ONE;
        end
        else
        begin
            c_f_next = xf[31:0];
        end
        if (yf > Q30_ONE_X)
        begin
            s_f_next = Q30_ONE;
        end
        else if (yf < -Q30_ONE_X)
        begin
            s_f_next = -Q30_ONE;
        end
        else
        begin
            s_f_next = yf[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_f_reg   <= c_f_next;
            s_f_reg   <= s_f_next;
            pre_f_reg <= cpre_reg[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Multiply: four products of (cos - 1) and sin with the rates.
    // ------------------------------------------------------------------
    logic signed [32:0] cm1;
    logic signed [31:0] vx_f;
    logic signed [31:0] vy_f;
    logic signed [64:0] p_cvy_reg;
    logic signed [64:0] p_cvx_reg;
    logic signed [63:0] p_svx_reg;
    logic signed [63:0] p_svy_reg;
    logic signed [31:0] c_m_reg;
    logic signed [31:0] s_m_reg;
    pre_t               pre_m_reg;

    assign cm1  = {c_f_reg[31], c_f_reg} - Q30_ONE_33;
    assign vx_f = pre_f_reg.vx;
    assign vy_f = pre_f_reg.vy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cvy_reg <= cm1 * vy_f;
            p_cvx_reg <= cm1 * vx_f;
            p_svx_reg <= s_f_reg * vx_f;
            p_svy_reg <= s_f_reg * vy_f;
            c_m_reg   <= c_f_reg;
            s_m_reg   <= s_f_reg;
            pre_m_reg <= pre_f_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sum into the two Q.46 numerators.
    // ------------------------------------------------------------------
    logic signed [65:0] numx_next;
    logic signed [65:0] numy_next;
    logic signed [65:0] numx_reg;
    logic signed [65:0] numy_reg;
    logic signed [31:0] c_s_reg;
    logic signed [31:0] s_s_reg;
    pre_t               pre_s_reg;

    assign numx_next = 66'(p_cvy_reg) + 66'(p_svx_reg);
    assign numy_next = 66'(p_svy_reg) - 66'(p_cvx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx_reg  <= numx_next;
            numy_reg  <= numy_next;
            c_s_reg   <= c_m_reg;
            s_s_reg   <= s_m_reg;
            pre_s_reg <= pre_m_reg;
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes and quotient signs.
    // ------------------------------------------------------------------
    logic [DIV_NW-1:0]  nx_next;
    logic [DIV_NW-1:0]  ny_next;
    logic [DIV_NW-1:0]  nx_reg;
    logic [DIV_NW-1:0]  ny_reg;
    logic               negx_a_reg;
    logic               negy_a_reg;
    logic signed [31:0] c_a_reg;
    logic signed [31:0] s_a_reg;
    pre_t               pre_a_reg;

    assign nx_next = numx_reg[65] ? DIV_NW'(-numx_reg) : DIV_NW'(numx_reg);
    assign ny_next = numy_reg[65] ? DIV_NW'(-numy_reg) : DIV_NW'(numy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg     <= nx_next;
            ny_reg     <= ny_next;
            negx_a_reg <= numx_reg[65] ^ pre_s_reg.w_neg;
            negy_a_reg <= numy_reg[65] ^ pre_s_reg.w_neg;
            c_a_reg    <= c_s_reg;
            s_a_reg    <= s_s_reg;
            pre_a_reg  <= pre_s_reg;
        end
    end

    // ------------------------------------------------------------------
    // Round half away: divide (n + 2|w|) by 4|w|.
    // ------------------------------------------------------------------
    logic [DIV_NW-1:0] dnx_reg;
    logic [DIV_NW-1:0] dny_reg;
    logic [DIV_DW-1:0] dden_reg;
    post_t             post_n_reg;
    post_t             post_n_next;

    always_comb
    begin
        post_n_next.lin  = pre_a_reg.lin;
        post_n_next.vx   = pre_a_reg.vx;
        post_n_next.vy   = pre_a_reg.vy;
        post_n_next.c    = c_a_reg;
        post_n_next.s    = s_a_reg;
        post_n_next.negx = negx_a_reg;
        post_n_next.negy = negy_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dnx_reg    <= nx_reg + {{(DIV_NW-33){1'b0}}, pre_a_reg.absw, 1'b0};
            dny_reg    <= ny_reg + {{(DIV_NW-33){1'b0}}, pre_a_reg.absw, 1'b0};
            dden_reg   <= {pre_a_reg.absw, 2'b00};
            post_n_reg <= post_n_next;
        end
    end

    // ------------------------------------------------------------------
    // Dividers, with the rest of the result riding alongside.
    // ------------------------------------------------------------------
    logic [DIV_QW-1:0] qx;
    logic [DIV_QW-1:0] qy;
    logic              bigx;
    logic              bigy;
    post_t             post_d_reg [DIV_QW];

    se2em_div u_div_x
    (
        .clk (clk),
        .en  (adv),
        .num (dnx_reg),
        .den (dden_reg),
        .quo (qx),
        .big (bigx)
    );

    se2em_div u_div_y
    (
        .clk (clk),
        .en  (adv),
        .num (dny_reg),
        .den (dden_reg),
        .quo (qy),
        .big (bigy)
    );

    for (genvar k = 0; k < DIV_QW; k++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                post_d_reg[k] <= (k == 0) ? post_n_reg : post_d_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: apply sign, saturate, or drop to the linear path.
    // ------------------------------------------------------------------
    post_t              pd;
    logic               ovfx;
    logic               ovfy;
    logic signed [31:0] tx_div;
    logic signed [31:0] ty_div;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic               lin_reg;
    logic               ovf_reg;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] tx_next;
    logic signed [31:0] ty_next;
    logic               ovf_next;

    assign pd   = post_d_reg[DIV_QW-1];
    assign ovfx = bigx || (pd.negx ? (qx > Q_NEG_MAX) : (qx > Q_POS_MAX));
    assign ovfy = bigy || (pd.negy ? (qy > Q_NEG_MAX) : (qy > Q_POS_MAX));

    always_comb
    begin
        if (ovfx)
        begin
            tx_div = pd.negx ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            tx_div = pd.negx ? (32'sd0 - $signed(qx[31:0])) : $signed(qx[31:0]);
        end
        if (ovfy)
        begin
            ty_div = pd.negy ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            ty_div = pd.negy ? (32'sd0 - $signed(qy[31:0])) : $signed(qy[31:0]);
        end

        if (pd.lin)
        begin
            cos_next = Q30_ONE;
            sin_next = '0;
            tx_next  = pd.vx;
            ty_next  = pd.vy;
            ovf_next = 1'b0;
        end
        else
        begin
            cos_next = pd.c;
            sin_next = pd.s;
            tx_next  = tx_div;
            ty_next  = ty_div;
            ovf_next = ovfx || ovfy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            lin_reg <= pd.lin;
            ovf_reg <= ovf_next;
        end
    end

    assign cos_theta   = cos_reg;
    assign sin_theta   = sin_reg;
    assign trans_x     = tx_reg;
    assign trans_y     = ty_reg;
    assign linear_path = lin_reg;
    assign overflow    = ovf_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SE2EM_ASSERT_IMP(a_lin_no_ovf, clk, rst_n, out_valid && linear_path, !overflow,
        "linear path result flags overflow")

    `SE2EM_ASSERT_IMP(a_lin_identity, clk, rst_n, out_valid && linear_path,
        (cos_theta == Q30_ONE) && (sin_theta == 32'sd0), "linear path rotation not identity")

    `SE2EM_ASSERT_IMP(a_ovf_saturated, clk, rst_n, out_valid && overflow,
        (trans_x == 32'sh7FFF_FFFF) || (trans_x == 32'sh8000_0000) ||
        (trans_y == 32'sh7FFF_FFFF) || (trans_y == 32'sh8000_0000),
        "overflow without a saturated translation")

    `SE2EM_ASSERT_NXT(a_drain, clk, rst_n, out_valid && out_ready && !vld_reg[LAT-2],
        !out_valid, "result appears with no request behind it")

endmodule

`default_nettype wire

@@ verif/se2_exponential_map_test.sv @@
// Self-checking testbench for the SE(2) exponential map pipeline.
`default_nettype none

module se2_exponential_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 24;
    localparam int LATENCY = (STAGES < 32 ? STAGES : 32) + 42;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam logic [30:0] TOL_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] TOL_DEFAULT = 31'd268;

    // Rounded atan(2^-i) in Q.30 radians, one entry per rotation stage.
    localparam longint ATAN_STEP [32] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048,
        1024, 512, 256, 128,
        64, 32, 16, 8,
        4, 2, 1, 0
    };

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } twist_t;

    typedef struct {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               lin;
        logic               ovf;
    } pose_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] rotation_rate = '0;
    logic signed [31:0] rate_x = '0;
    logic signed [31:0] rate_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] cos_theta;
    logic signed [31:0] sin_theta;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic               linear_path;
    logic               overflow;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [30:0]        cfg_data = '0;

    se2_exponential_map #(.ROTATION_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .rotation_rate(rotation_rate), .rate_x(rate_x), .rate_y(rate_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .cos_theta(cos_theta), .sin_theta(sin_theta),
        .trans_x(trans_x), .trans_y(trans_y),
        .linear_path(linear_path), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    twist_t      pending_twists[$];
    pose_t       expected_poses[$];
    logic [30:0] tol_model = TOL_DEFAULT;
    int          errors = 0;
    int          poses_seen = 0;
    int          linear_seen = 0;
    int          ovf_seen = 0;
    bit          burst_mode = 1'b0;

    // Divide a Q.46 numerator by the Q.28 angle, round half away from zero,
    // saturate to 32 bits.
    function automatic logic [31:0] divide_by_angle(input longint num, input longint w,
                                                    output bit sat);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        bit neg;
        n = num < 0 ? -num : num;
        d = w < 0 ? -w : w;
        q = (n + 2 * d) / (4 * d);
        neg = (num < 0) != (w < 0);
        sat = 1'b0;
        if (neg) begin
            if (q > 64'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-longint'(q));
        end
        if (q > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return 32'(q);
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    // Work out the pose one twist generates under the given tolerance.
    function automatic pose_t predict_pose(input twist_t t, input logic [30:0] tol);
        longint w, vx, vy, mag, z, x, y, dx, dy, c, s, cm1;
        bit flip, sat_x, sat_y;
        pose_t p;
        w = t.w;
        vx = t.vx;
        vy = t.vy;
        mag = w < 0 ? -w : w;
        p.lin = (w == 0) || (mag < longint'(tol));
        p.ovf = 1'b0;
        if (p.lin) begin
            p.c = ONE_Q30[31:0];
            p.s = '0;
            p.tx = t.vx;
            p.ty = t.vy;
            return p;
        end
        // Reduce into [-pi/2, pi/2], remembering a half-turn as a sign flip.
        z = w * 4;
        flip = 1'b0;
        if (z > PI_Q30) z -= TWO_PI_Q30;
        else if (z < -PI_Q30) z += TWO_PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_STEP[i];
            end else begin
                x += dx; y -= dy; z += ATAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_unit(x);
        s = clamp_unit(y);
        cm1 = c - ONE_Q30;
        p.c = c[31:0];
        p.s = s[31:0];
        p.tx = divide_by_angle(cm1 * vy + s * vx, w, sat_x);
        p.ty = divide_by_angle(s * vy - cm1 * vx, w, sat_y);
        p.ovf = sat_x | sat_y;
        return p;
    endfunction

    // Mostly short gaps, now and then a long one; none at all in burst mode.
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 19);
        if (r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request driver: hold a request until accepted, then advance the queue.
    int twist_gap = 0;
    always @(posedge clk) begin
        twist_t t;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                t.w = rotation_rate;
                t.vx = rate_x;
                t.vy = rate_y;
                expected_poses.push_back(predict_pose(t, tol_model));
            end
            if (!(in_valid && !in_ready)) begin
                if (twist_gap > 0) begin
                    twist_gap--;
                    in_valid <= 1'b0;
                end else if (pending_twists.size() > 0) begin
                    t = pending_twists.pop_front();
                    rotation_rate <= t.w;
                    rate_x <= t.vx;
                    rate_y <= t.vy;
                    in_valid <= 1'b1;
                    twist_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted pose with the oldest prediction.
    // After 200 results, hold off for a long stretch so the pipeline fills
    // up and stalls its input.
    int pose_hold = 0;
    bit long_hold_done = 1'b0;
    always @(posedge clk) begin
        pose_t e;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                poses_seen++;
                if (expected_poses.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pose c=%0d s=%0d tx=%0d ty=%0d", $time,
                             cos_theta, sin_theta, trans_x, trans_y);
                end else begin
                    e = expected_poses.pop_front();
                    if (e.lin) linear_seen++;
                    if (e.ovf) ovf_seen++;
                    if (cos_theta !== e.c) begin
                        errors++;
                        $display("%0t: cos_theta expected %0d actual %0d", $time, e.c, cos_theta);
                    end
                    if (sin_theta !== e.s) begin
                        errors++;
                        $display("%0t: sin_theta expected %0d actual %0d", $time, e.s, sin_theta);
                    end
                    if (trans_x !== e.tx) begin
                        errors++;
                        $display("%0t: trans_x expected %0d actual %0d", $time, e.tx, trans_x);
                    end
                    if (trans_y !== e.ty) begin
                        errors++;
                        $display("%0t: trans_y expected %0d actual %0d", $time, e.ty, trans_y);
                    end
                    if (linear_path !== e.lin) begin
                        errors++;
                        $display("%0t: linear_path expected %0b actual %0b", $time,
                                 e.lin, linear_path);
                    end
                    if (overflow !== e.ovf) begin
                        errors++;
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 e.ovf, overflow);
                    end
                end
            end
            if (!long_hold_done && poses_seen >= 200) begin
                long_hold_done = 1'b1;
                pose_hold = 300;
            end
            if (pose_hold > 0) begin
                pose_hold--;
                out_ready <= 1'b0;
            end else if (burst_mode) begin
                out_ready <= 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0: pose_hold = $urandom_range(10, 40);
                    1, 2, 3, 4: pose_hold = $urandom_range(1, 3);
                    default: pose_hold = 0;
                endcase
                out_ready <= (pose_hold == 0);
            end
        end
    end

    task automatic queue_twist(input logic [31:0] w, input logic [31:0] vx,
                               input logic [31:0] vy);
        twist_t t;
        t.w = w;
        t.vx = vx;
        t.vy = vy;
        pending_twists.push_back(t);
    endtask

    // Drain everything in flight, then let the pipeline settle.
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_twists.size() != 0 || in_valid || expected_poses.size() != 0);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [30:0] tol);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= tol;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_model = tol;
    endtask

    // Random twist: half full-range, the rest near the tolerance, near zero, or near
    // the pi/2 fold and -pi wrap boundaries.
    task automatic queue_random_twists(input int count);
        logic [31:0] w;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0: w = $urandom_range(0, 2 * tol_model + 16) - tol_model - 8;
                1: w = $urandom_range(0, 4000) - 2000;
                2: w = 32'sd421657428 + $urandom_range(0, 200) - 100;
                3: w = -32'sd843314856 + $urandom_range(0, 200) - 100;
                default: w = $urandom;
            endcase
            queue_twist(w, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset tolerance, extremes of angle and rates.
        queue_twist(32'sd0, 32'sd0, 32'sd0);
        queue_twist(32'sd267, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_twist(32'sd268, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_twist(-32'sd268, 32'sd65536, -32'sd65536);
        queue_twist(-32'sd267, 32'sd1, -32'sd1);
        queue_twist(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_twist(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_twist(32'sd421657428, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_twist(32'sd843314857, 32'h8000_0000, 32'h8000_0000);
        queue_twist(-32'sd843314857, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_twist(32'sd1686629713, 32'sd65536, 32'sd65536);
        wait_idle();

        // Zero tolerance: tiny angles take the rotation path and can saturate.
        write_tolerance('0);
        queue_twist(32'sd0, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_twist(32'sd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_twist(-32'sd1, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_twist(32'sd2, 32'h8000_0000, 32'h8000_0000);
        queue_twist(32'sd100, 32'h7FFF_FFFF, 32'sd0);
        wait_idle();

        // Largest tolerance: every angle but the most positive and the two most negative is linear.
        write_tolerance(TOL_MAX);
        queue_twist(32'h7FFF_FFFF, 32'sd12345, -32'sd12345);
        queue_twist(32'h8000_0000, 32'sd7, 32'sd9);
        queue_twist(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        queue_random_twists(160);
        wait_idle();
        write_tolerance('0);
        queue_random_twists(160);
        wait_idle();
        write_tolerance(TOL_DEFAULT);
        queue_random_twists(160);
        wait_idle();
        write_tolerance(31'($urandom_range(0, 32'h7FFF_FFFF)));
        queue_random_twists(160);
        wait_idle();
        write_tolerance(31'($urandom_range(0, 65535)));
        queue_random_twists(160);
        wait_idle();

        $display("Checked %0d poses over several tolerance settings: %0d linear, %0d saturated.",
                 poses_seen, linear_seen, ovf_seen);
        $display("Random gaps and stalls on both sides, one long output hold-off.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
